>>> rtl/core/mrfd_pkg.sv
// Shared constants, types and frame layout for the meter response frame decoder.
package mrfd_pkg;

    localparam int FRAME_BYTES = 25;
    localparam int IDX_W       = 5;

    typedef logic [IDX_W-1:0] idx_t;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Byte positions within the response frame
    localparam idx_t POS_VOLT    = idx_t'(3);
    localparam idx_t POS_CURR    = idx_t'(5);
    localparam idx_t POS_POWER   = idx_t'(9);
    localparam idx_t POS_ENERGY  = idx_t'(13);
    localparam idx_t POS_FREQ    = idx_t'(17);
    localparam idx_t POS_PF      = idx_t'(19);
    localparam idx_t POS_ALARM   = idx_t'(21);
    localparam idx_t POS_CRC_LO  = idx_t'(FRAME_BYTES - 2);
    localparam idx_t POS_CRC_HI  = idx_t'(FRAME_BYTES - 1);

    typedef struct packed {
        logic       fire;
        logic       start;
        logic [7:0] data;
    } mrfd_step_t;

    typedef struct packed {
        logic [15:0] voltage_raw;
        logic [31:0] current_raw;
        logic [31:0] power_raw;
        logic [31:0] energy_raw;
        logic [15:0] frequency_raw;
        logic [15:0] power_factor_raw;
        logic [15:0] alarm_word;
        logic        crc_ok;
    } mrfd_result_t;

endpackage

>>> rtl/core/meter_response_frame_decoder.sv
// Top level of the meter response frame decoder: input register, parser, result register.
// Takes a 25-byte meter read response one byte per transfer and, on the last byte,
// delivers one result with the raw voltage, current, power, energy, frequency, power
// factor and alarm registers plus crc_ok (CRC-16/MODBUS over bytes 0..22 against bytes
// 23/24, low byte first). frame_start forces the byte to be byte 0 and drops any partial
// frame; bytes without it continue the current frame, wrapping after byte 24. A byte
// transfer is taken every cycle unless a final byte is held back; the last byte passes
// through the input register and then the result register, which raises out_valid. The rate
// is set by the bytewise CRC update, which sits between the input register and the result
// register. A pending result does not block bytes that produce no result; only a final
// byte waits for the result register to drain.
module meter_response_frame_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    input  logic        frame_start,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] voltage_raw,
    output logic [31:0] current_raw,
    output logic [31:0] power_raw,
    output logic [31:0] energy_raw,
    output logic [15:0] frequency_raw,
    output logic [15:0] power_factor_raw,
    output logic [15:0] alarm_word,
    output logic        crc_ok
);
    import mrfd_pkg::*;

    // input register
    logic         s1_valid_reg, s1_valid_next;
    logic [7:0]   s1_byte_reg;
    logic         s1_start_reg;

    // result register
    logic         out_valid_reg, out_valid_next;
    mrfd_result_t out_reg;

    mrfd_step_t   step;
    mrfd_result_t result;
    logic         emit;
    logic         out_free;
    logic         s1_fire;
    logic         in_take;

    assign out_free = !out_valid_reg || !out_stall;
    // a final byte needs room in the result register; other bytes always move
    assign s1_fire  = s1_valid_reg && (!emit || out_free);
    assign in_stall = s1_valid_reg && !s1_fire;
    assign in_take  = in_valid && !in_stall;

    assign step.fire  = s1_fire;
    assign step.start = s1_start_reg;
    assign step.data  = s1_byte_reg;

    mrfd_parser u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .emit   (emit),
        .result (result)
    );

    always_comb
    begin
        s1_valid_next  = in_take || (s1_valid_reg && !s1_fire);
        out_valid_next = (s1_fire && emit) || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_byte_reg  <= rx_byte;
            s1_start_reg <= frame_start;
        end
        if (s1_fire && emit)
            out_reg <= result;
    end

    assign out_valid        = out_valid_reg;
    assign voltage_raw      = out_reg.voltage_raw;
    assign current_raw      = out_reg.current_raw;
    assign power_raw        = out_reg.power_raw;
    assign energy_raw       = out_reg.energy_raw;
    assign frequency_raw    = out_reg.frequency_raw;
    assign power_factor_raw = out_reg.power_factor_raw;
    assign alarm_word       = out_reg.alarm_word;
    assign crc_ok           = out_reg.crc_ok;

    // a final byte never overwrites a result that is still held
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        !(s1_fire && emit && out_valid_reg && out_stall))
        else $error("result register overwritten while stalled");

    // a completed frame shows up as a result on the next cycle
    a_emit_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && emit) |=> out_valid)
        else $error("final byte did not produce a result");

    // input is held back only by a pending final byte
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && emit && out_valid_reg && out_stall))
        else $error("input stalled without a blocked final byte");

endmodule

>>> rtl/core/mrfd_crc.sv
// Bytewise CRC-16/MODBUS update (reflected, eight shift steps).
module mrfd_crc (
    input  logic [15:0] crc_in,
    input  logic [7:0]  data,
    output logic [15:0] crc_out
);
    import mrfd_pkg::*;

    logic [15:0] acc;

    always_comb
    begin
        acc = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++)
        begin
            if (acc[0])
                acc = (acc >> 1) ^ CRC_POLY;
            else
                acc = acc >> 1;
        end
        crc_out = acc;
    end

endmodule

>>> rtl/core/mrfd_parser.sv
// Frame position tracking, running CRC and field capture.
module mrfd_parser (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mrfd_pkg::mrfd_step_t  step,
    output logic                  emit,
    output mrfd_pkg::mrfd_result_t result
);
    import mrfd_pkg::*;

    idx_t        byte_index_reg, byte_index_next;
    logic [15:0] running_crc_reg, running_crc_next;
    idx_t        idx_cur;
    logic [15:0] crc_base;
    logic [15:0] crc_upd;

    logic [15:0] voltage_reg;
    logic [31:0] current_reg;
    logic [31:0] power_reg;
    logic [31:0] energy_reg;
    logic [15:0] frequency_reg;
    logic [15:0] factor_reg;
    logic [15:0] alarm_reg;
    logic [7:0]  crc_low_reg;

    mrfd_crc u_crc (
        .crc_in  (crc_base),
        .data    (step.data),
        .crc_out (crc_upd)
    );

    always_comb
    begin
        idx_cur  = step.start ? '0 : byte_index_reg;
        crc_base = step.start ? CRC_INIT : running_crc_reg;
        emit     = (idx_cur >= POS_CRC_HI);

        byte_index_next  = byte_index_reg;
        running_crc_next = running_crc_reg;
        if (step.fire)
        begin
            if (emit)
            begin
                byte_index_next  = '0;
                running_crc_next = CRC_INIT;
            end
            else
            begin
                byte_index_next  = idx_cur + idx_t'(1);
                running_crc_next = (idx_cur < POS_CRC_LO) ? crc_upd : crc_base;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg  <= '0;
            running_crc_reg <= CRC_INIT;
        end
        else
        begin
            byte_index_reg  <= byte_index_next;
            running_crc_reg <= running_crc_next;
        end
    end

    // Word fields are big-endian; 32-bit fields carry the low word first.
    always_ff @(posedge clk)
    begin
        if (step.fire)
        begin
            unique case (idx_cur)
                POS_VOLT:                    voltage_reg[15:8]   <= step.data;
                POS_VOLT + idx_t'(1):        voltage_reg[7:0]    <= step.data;
                POS_CURR:                    current_reg[15:8]   <= step.data;
                POS_CURR + idx_t'(1):        current_reg[7:0]    <= step.data;
                POS_CURR + idx_t'(2):        current_reg[31:24]  <= step.data;
                POS_CURR + idx_t'(3):        current_reg[23:16]  <= step.data;
                POS_POWER:                   power_reg[15:8]     <= step.data;
                POS_POWER + idx_t'(1):       power_reg[7:0]      <= step.data;
                POS_POWER + idx_t'(2):       power_reg[31:24]    <= step.data;
                POS_POWER + idx_t'(3):       power_reg[23:16]    <= step.data;
                POS_ENERGY:                  energy_reg[15:8]    <= step.data;
                POS_ENERGY + idx_t'(1):      energy_reg[7:0]     <= step.data;
                POS_ENERGY + idx_t'(2):      energy_reg[31:24]   <= step.data;
                POS_ENERGY + idx_t'(3):      energy_reg[23:16]   <= step.data;
                POS_FREQ:                    frequency_reg[15:8] <= step.data;
                POS_FREQ + idx_t'(1):        frequency_reg[7:0]  <= step.data;
                POS_PF:                      factor_reg[15:8]    <= step.data;
                POS_PF + idx_t'(1):          factor_reg[7:0]     <= step.data;
                POS_ALARM:                   alarm_reg[15:8]     <= step.data;
                POS_ALARM + idx_t'(1):       alarm_reg[7:0]      <= step.data;
                POS_CRC_LO:                  crc_low_reg         <= step.data;
                default:                     ;
            endcase
        end
    end

    always_comb
    begin
        result.voltage_raw      = voltage_reg;
        result.current_raw      = current_reg;
        result.power_raw        = power_reg;
        result.energy_raw       = energy_reg;
        result.frequency_raw    = frequency_reg;
        result.power_factor_raw = factor_reg;
        result.alarm_word       = alarm_reg;
        result.crc_ok           = ({step.data, crc_low_reg} == crc_base);
    end

endmodule

>>> tb/tb_meter_response_frame_decoder.sv
// Testbench for the meter response frame decoder: predicted readings checked against DUT output.
`timescale 1ns / 1ps

module tb_meter_response_frame_decoder;
    import mrfd_pkg::*;

    // Directed bytes come first; after them the random part runs in four
    // idling phases of roughly equal size.
    localparam int DIRECTED_BYTES = 56;
    localparam int TOTAL_BYTES    = 950;
    localparam int PHASE_BYTES    = (TOTAL_BYTES - DIRECTED_BYTES) / 4;
    localparam int HOLDOFF_CYCLES = 300;     // long receiver hold, several frames deep
    localparam int DRAIN_CYCLES   = 20;      // idle cycles after the final drain

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  rx_byte;
    logic        frame_start;
    logic        out_valid;
    logic        out_stall;
    logic [15:0] voltage_raw;
    logic [31:0] current_raw;
    logic [31:0] power_raw;
    logic [31:0] energy_raw;
    logic [15:0] frequency_raw;
    logic [15:0] power_factor_raw;
    logic [15:0] alarm_word;
    logic        crc_ok;

    meter_response_frame_decoder dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .rx_byte          (rx_byte),
        .frame_start      (frame_start),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .voltage_raw      (voltage_raw),
        .current_raw      (current_raw),
        .power_raw        (power_raw),
        .energy_raw       (energy_raw),
        .frequency_raw    (frequency_raw),
        .power_factor_raw (power_factor_raw),
        .alarm_word       (alarm_word),
        .crc_ok           (crc_ok)
    );

    // Scoreboard: tracks the decoder's frame position, running CRC and the
    // field captures, and queues one expected reading per completed frame.
    class frame_decode_model;
        idx_t         byte_pos;
        logic [15:0]  crc_acc;
        logic [15:0]  volt_cap;
        logic [31:0]  curr_cap;
        logic [31:0]  power_cap;
        logic [31:0]  energy_cap;
        logic [15:0]  freq_cap;
        logic [15:0]  pf_cap;
        logic [15:0]  alarm_cap;
        logic [7:0]   crc_lo_cap;
        mrfd_result_t readings_due[$];
        int           errors;

        function new();
            byte_pos   = '0;
            crc_acc    = CRC_INIT;
            volt_cap   = '0;
            curr_cap   = '0;
            power_cap  = '0;
            energy_cap = '0;
            freq_cap   = '0;
            pf_cap     = '0;
            alarm_cap  = '0;
            crc_lo_cap = '0;
            errors     = 0;
        endfunction

        // Bytewise CRC-16/MODBUS, reflected, LSB first.
        static function logic [15:0] crc_next(logic [15:0] c, logic [7:0] b);
            logic [15:0] r;
            r = c ^ {8'h00, b};
            for (int k = 0; k < 8; k++)
                r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
            return r;
        endfunction

        function int pending();
            return readings_due.size();
        endfunction

        // Accepted input byte.
        function void take_byte(logic [7:0] b, logic st);
            mrfd_result_t r;
            if (st)
            begin
                byte_pos = '0;
                crc_acc  = CRC_INIT;
            end
            if (byte_pos < POS_CRC_LO)
                crc_acc = crc_next(crc_acc, b);
            // 16-bit words are big-endian; 32-bit values send the low word first
            case (byte_pos)
                POS_VOLT:            volt_cap[15:8]    = b;
                POS_VOLT + 5'd1:     volt_cap[7:0]     = b;
                POS_CURR:            curr_cap[15:8]    = b;
                POS_CURR + 5'd1:     curr_cap[7:0]     = b;
                POS_CURR + 5'd2:     curr_cap[31:24]   = b;
                POS_CURR + 5'd3:     curr_cap[23:16]   = b;
                POS_POWER:           power_cap[15:8]   = b;
                POS_POWER + 5'd1:    power_cap[7:0]    = b;
                POS_POWER + 5'd2:    power_cap[31:24]  = b;
                POS_POWER + 5'd3:    power_cap[23:16]  = b;
                POS_ENERGY:          energy_cap[15:8]  = b;
                POS_ENERGY + 5'd1:   energy_cap[7:0]   = b;
                POS_ENERGY + 5'd2:   energy_cap[31:24] = b;
                POS_ENERGY + 5'd3:   energy_cap[23:16] = b;
                POS_FREQ:            freq_cap[15:8]    = b;
                POS_FREQ + 5'd1:     freq_cap[7:0]     = b;
                POS_PF:              pf_cap[15:8]      = b;
                POS_PF + 5'd1:       pf_cap[7:0]       = b;
                POS_ALARM:           alarm_cap[15:8]   = b;
                POS_ALARM + 5'd1:    alarm_cap[7:0]    = b;
                default: ;
            endcase
            if (byte_pos == POS_CRC_LO)
                crc_lo_cap = b;
            if (byte_pos >= POS_CRC_HI)
            begin
                r.voltage_raw      = volt_cap;
                r.current_raw      = curr_cap;
                r.power_raw        = power_cap;
                r.energy_raw       = energy_cap;
                r.frequency_raw    = freq_cap;
                r.power_factor_raw = pf_cap;
                r.alarm_word       = alarm_cap;
                r.crc_ok           = ({b, crc_lo_cap} == crc_acc);
                readings_due.push_back(r);
                byte_pos = '0;
                crc_acc  = CRC_INIT;
            end
            else
                byte_pos = byte_pos + 5'd1;
        endfunction

        function void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (exp_v !== act_v)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
            end
        endfunction

        // Accepted reading from the DUT, compared with the oldest expectation.
        function void match_reading(mrfd_result_t act);
            mrfd_result_t e;
            if (readings_due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected reading, expected none actual %h", $time, act);
                return;
            end
            e = readings_due.pop_front();
            check_field("voltage_raw", 32'(e.voltage_raw), 32'(act.voltage_raw));
            check_field("current_raw", e.current_raw, act.current_raw);
            check_field("power_raw", e.power_raw, act.power_raw);
            check_field("energy_raw", e.energy_raw, act.energy_raw);
            check_field("frequency_raw", 32'(e.frequency_raw), 32'(act.frequency_raw));
            check_field("power_factor_raw", 32'(e.power_factor_raw),
                        32'(act.power_factor_raw));
            check_field("alarm_word", 32'(e.alarm_word), 32'(act.alarm_word));
            check_field("crc_ok", 32'(e.crc_ok), 32'(act.crc_ok));
        endfunction
    endclass

    frame_decode_model decoder_model = new();

    // Idling knobs, percent per cycle; changed at phase boundaries.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_request   = 1'b0;   // asks the receiver for one long holdoff
    int bytes_sent     = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Runaway guard, far beyond the slowest legal run.
    initial
    begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

    // One byte transfer. Random idle cycles go in front; the byte is noted
    // in the scoreboard only once the DUT has taken it.
    task automatic send_byte(input logic [7:0] b, input logic st);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        rx_byte     <= b;
        frame_start <= st;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        decoder_model.take_byte(b, st);
        bytes_sent++;
    endtask

    // Builds a response frame around the given field values and sends its first
    // nbytes bytes. With corrupt set, one bit flips after the CRC is appended,
    // either in one of bytes 0..22 or in the CRC itself.
    task automatic send_frame(input mrfd_result_t v, input int nbytes,
                              input bit with_start, input bit corrupt);
        logic [7:0]  fb [FRAME_BYTES];
        logic [15:0] c;
        fb[0]  = ($urandom_range(3) == 0) ? 8'($urandom) : 8'h01;   // address
        fb[1]  = ($urandom_range(7) == 0) ? 8'($urandom) : 8'h04;   // function code
        fb[2]  = ($urandom_range(7) == 0) ? 8'($urandom) : 8'h14;   // byte count
        fb[3]  = v.voltage_raw[15:8];
        fb[4]  = v.voltage_raw[7:0];
        fb[5]  = v.current_raw[15:8];
        fb[6]  = v.current_raw[7:0];
        fb[7]  = v.current_raw[31:24];
        fb[8]  = v.current_raw[23:16];
        fb[9]  = v.power_raw[15:8];
        fb[10] = v.power_raw[7:0];
        fb[11] = v.power_raw[31:24];
        fb[12] = v.power_raw[23:16];
        fb[13] = v.energy_raw[15:8];
        fb[14] = v.energy_raw[7:0];
        fb[15] = v.energy_raw[31:24];
        fb[16] = v.energy_raw[23:16];
        fb[17] = v.frequency_raw[15:8];
        fb[18] = v.frequency_raw[7:0];
        fb[19] = v.power_factor_raw[15:8];
        fb[20] = v.power_factor_raw[7:0];
        fb[21] = v.alarm_word[15:8];
        fb[22] = v.alarm_word[7:0];
        c = CRC_INIT;
        for (int i = 0; i < FRAME_BYTES - 2; i++)
            c = frame_decode_model::crc_next(c, fb[i]);
        fb[23] = c[7:0];
        fb[24] = c[15:8];
        if (corrupt)
        begin
            if ($urandom_range(1) == 0)
                fb[23 + $urandom_range(1)] ^= 8'(1 << $urandom_range(7));
            else
                fb[$urandom_range(22)] ^= 8'(1 << $urandom_range(7));
        end
        for (int i = 0; i < nbytes; i++)
            send_byte(fb[i], (i == 0) ? with_start : 1'b0);
    endtask

    // Field values lean toward the extremes now and then.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic mrfd_result_t random_reading();
        mrfd_result_t v;
        v.voltage_raw      = 16'(pick_value());
        v.current_raw      = pick_value();
        v.power_raw        = pick_value();
        v.energy_raw       = pick_value();
        v.frequency_raw    = 16'(pick_value());
        v.power_factor_raw = 16'(pick_value());
        v.alarm_word       = 16'(pick_value());
        v.crc_ok           = 1'b0;
        return v;
    endfunction

    // Sender pause: nothing offered until every expected reading is out.
    task automatic wait_drain();
        in_valid <= 1'b0;
        while (decoder_model.pending() != 0)
            @(posedge clk);
    endtask

    // Receiver: checks each accepted reading, then picks the next cycle's
    // stall. A holdoff request pins stall high for a counted stretch.
    initial
    begin
        int holdoff_left;
        holdoff_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
                decoder_model.match_reading({voltage_raw, current_raw, power_raw, energy_raw,
                                             frequency_raw, power_factor_raw, alarm_word,
                                             crc_ok});
            if (hold_request)
            begin
                holdoff_left = HOLDOFF_CYCLES;
                hold_request = 1'b0;
            end
            if (holdoff_left > 0)
                holdoff_left--;
            out_stall <= (holdoff_left > 0) || ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Main sequence: reset, directed frames, then four idling phases of
    // mostly well-formed frames mixed with corrupt, cut-off and noise traffic.
    initial
    begin
        mrfd_result_t vals;
        int           sel;
        int           n;
        bit           aligned;

        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        rx_byte     <= 8'h00;
        frame_start <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Bytes with no start flag right after reset count from byte 0;
        // every field at its maximum, CRC good.
        vals = '1;
        send_frame(vals, FRAME_BYTES, 1'b0, 1'b0);
        // A start flag mid-frame drops the partial frame; the new one has all
        // fields set to zero and one bit flipped after the CRC, so crc_ok must come back low.
        send_frame(random_reading(), 6, 1'b1, 1'b0);
        vals = '0;
        send_frame(vals, FRAME_BYTES, 1'b1, 1'b1);

        aligned = 1'b1;
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    hold_request   = 1'b1;   // input must back up during this hold
                end
                1:
                begin
                    send_idle_pct  = 52;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 52;
                end
                default:
                begin
                    send_idle_pct  = 35;
                    recv_stall_pct = 35;
                end
            endcase
            while (bytes_sent < DIRECTED_BYTES + (ph + 1) * PHASE_BYTES)
            begin
                sel = $urandom_range(99);
                if (sel < 70)
                begin
                    // Well-formed frame; once aligned, the start flag is sometimes
                    // left off to exercise the wrap after byte 24.
                    send_frame(random_reading(), FRAME_BYTES,
                               aligned ? ($urandom_range(4) != 0) : 1'b1, 1'b0);
                    aligned = 1'b1;
                end
                else if (sel < 80)
                begin
                    send_frame(random_reading(), FRAME_BYTES, 1'b1, 1'b1);
                    aligned = 1'b1;
                end
                else if (sel < 90)
                begin
                    // Cut-off frame; the next one restarts with a start flag
                    n = $urandom_range(FRAME_BYTES - 1, 1);
                    send_frame(random_reading(), n, 1'b1, 1'b0);
                    aligned = 1'b0;
                end
                else
                begin
                    // Line noise, occasionally carrying a stray start flag
                    n = $urandom_range(10, 1);
                    for (int i = 0; i < n; i++)
                        send_byte(8'($urandom), $urandom_range(9) == 0);
                    aligned = 1'b0;
                end
            end
            wait_drain();
        end

        in_valid <= 1'b0;
        wait_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (decoder_model.errors == 0 && decoder_model.pending() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
